// ===== rtl/pcc_pkg.sv =====
// pcc_pkg: shared types, constants and helper functions of the progressive caesar codec
// no dependencies; used by pcc_cfg, pcc_front, pcc_drain and the top level through scoped names
package pcc_pkg;

	localparam int EOM_LEN = 7;

	localparam logic [7:0] CH_US = 8'h5F;
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_O  = 8'h4F;
	localparam logic [7:0] CH_M  = 8'h4D;

	localparam logic [1:0] REG_KEY  = 2'd0;
	localparam logic [1:0] REG_MODE = 2'd1;
	localparam logic [1:0] REG_CAP  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_OVF    = 2'd1;
	localparam logic [1:0] ST_NOMARK = 2'd2;

	localparam logic MODE_ENC = 1'b0;

	typedef enum logic [1:0] {
		CODE_RAW = 2'd0,
		CODE_ENC = 2'd1,
		CODE_DEC = 2'd2
	} code_t;

	typedef struct packed {
		logic       mode;
		logic [4:0] s26;
		logic [3:0] s10;
	} cfg_t;

	// one accepted item's worth of output beats
	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] nb;
		logic [2:0] pre;
		code_t      code;
		logic       fin;
		logic [1:0] status;
		logic       use_cnt;
	} bundle_t;

	function automatic logic [7:0] eom_at(input logic [2:0] idx);
		logic [7:0] b;
		case (idx) inside
			3'd0, 3'd1, 3'd5, 3'd6: b = CH_US;
			3'd2:                   b = CH_E;
			3'd3:                   b = CH_O;
			3'd4:                   b = CH_M;
			default:                b = 8'h00;
		endcase
		return b;
	endfunction

	// held bytes are the marker prefix of length fill, then ch; smallest shift that
	// leaves a marker prefix is the number of bytes let go
	function automatic logic [2:0] release_count(input logic [2:0] fill, input logic [7:0] ch);
		logic [2:0] r;
		logic       ok;
		r = fill + 3'd1;
		for (int s = EOM_LEN; s >= 1; s--) begin
			ok = (s <= int'(fill)) && (ch == eom_at(3'(int'(fill) - s)));
			for (int i = 0; i < EOM_LEN - 1; i++) begin
				if ((i + s < int'(fill)) && (eom_at(3'(i + s)) != eom_at(3'(i))))
					ok = 1'b0;
			end
			if (ok)
				r = 3'(s);
		end
		return r;
	endfunction

endpackage

// ===== rtl/pcc_cfg.sv =====
// pcc_cfg: configuration registers, key residues mod 26 and mod 10, clamped capacity
// depends on pcc_pkg
module pcc_cfg #(
	parameter int MAX_CAPACITY = 65535,
	parameter int CW = $clog2(MAX_CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output pcc_pkg::cfg_t       cfg,
	output logic [CW-1:0]       cap
);

	pcc_pkg::cfg_t cfg_q;
	logic [CW-1:0] cap_q;

	logic [15:0] u;
	logic [31:0] prod26;
	logic [31:0] prod10;
	logic [15:0] r26w;
	logic [15:0] r10w;
	logic [5:0]  t26;
	logic [4:0]  t10;
	logic [4:0]  s26_n;
	logic [3:0]  s10_n;
	logic        wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid & cfg_ready;

	// key + 32768 as unsigned, reciprocal multiply for the quotients
	assign u      = cfg_data ^ 16'h8000;
	assign prod26 = {16'd0, u} * 32'd20165;
	assign prod10 = {16'd0, u} * 32'd52429;
	assign r26w   = u - 16'(prod26[31:19]) * 16'd26;
	assign r10w   = u - 16'(prod10[31:19]) * 16'd10;
	// 32768 is 8 mod 26 and 8 mod 10
	assign t26    = {1'b0, r26w[4:0]} + 6'd18;
	assign t10    = {1'b0, r10w[3:0]} + 5'd2;
	assign s26_n  = (t26 >= 6'd26) ? 5'(t26 - 6'd26) : t26[4:0];
	assign s10_n  = (t10 >= 5'd10) ? 4'(t10 - 5'd10) : t10[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
			cap_q <= CW'(MAX_CAPACITY);
		end else if (wr) begin
			unique case (cfg_index)
				pcc_pkg::REG_KEY: begin
					cfg_q.s26 <= s26_n;
					cfg_q.s10 <= s10_n;
				end
				pcc_pkg::REG_MODE: cfg_q.mode <= cfg_data[0];
				pcc_pkg::REG_CAP: begin
					cap_q <= (cfg_data > 16'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY)
						: cfg_data[CW-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
	assign cap = cap_q;

endmodule

// ===== rtl/pcc_front.sv =====
// pcc_front: per-string state and the decision what beats an accepted byte or end mark gives
// depends on pcc_pkg; feeds pcc_drain with at most one bundle per accepted item
module pcc_front #(
	parameter int CW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic [7:0]         ch_in,
	input  logic               end_mark,
	input  pcc_pkg::cfg_t      cfg,
	input  logic [CW-1:0]      cap,
	output logic               bnd_vld,
	output pcc_pkg::bundle_t   bnd
);

	logic [CW-1:0] wr_q, wr_n;
	logic          ovf_q, ovf_n;
	logic          mkr_q, mkr_n;
	logic [2:0]    fill_q, fill_n;

	logic          room_ok;
	logic          no_eom_room;
	logic [CW-1:0] room;
	logic [2:0]    rel;
	logic [2:0]    sent;

	assign room_ok     = ({1'b0, wr_q} + (CW+1)'(1)) < {1'b0, cap};
	assign no_eom_room = ({1'b0, wr_q} + (CW+1)'(pcc_pkg::EOM_LEN + 1)) > {1'b0, cap};
	assign room        = cap - wr_q - CW'(1);
	assign rel         = pcc_pkg::release_count(fill_q, ch_in);
	assign sent        = !room_ok ? 3'd0 : ((room < CW'(rel)) ? room[2:0] : rel);

	always_comb begin
		bnd     = '0;
		bnd_vld = 1'b0;
		wr_n    = wr_q;
		ovf_n   = ovf_q;
		mkr_n   = mkr_q;
		fill_n  = fill_q;
		if (acc) begin
			if (end_mark) begin
				bnd_vld = 1'b1;
				bnd.fin = 1'b1;
				wr_n    = '0;
				ovf_n   = 1'b0;
				mkr_n   = 1'b0;
				fill_n  = '0;
				if (cfg.mode == pcc_pkg::MODE_ENC) begin
					if (ovf_q || no_eom_room) begin
						bnd.status = pcc_pkg::ST_OVF;
					end else begin
						bnd.nb      = 3'(pcc_pkg::EOM_LEN);
						bnd.pre     = 3'(pcc_pkg::EOM_LEN);
						bnd.status  = pcc_pkg::ST_OK;
						bnd.use_cnt = 1'b1;
					end
				end else if (cap == '0) begin
					bnd.status = pcc_pkg::ST_OK;
				end else if (mkr_q) begin
					bnd.status  = pcc_pkg::ST_OK;
					bnd.use_cnt = 1'b1;
				end else begin
					bnd.status = pcc_pkg::ST_NOMARK;
				end
			end else if (cfg.mode == pcc_pkg::MODE_ENC) begin
				if (!ovf_q) begin
					if (!room_ok) begin
						ovf_n = 1'b1;
					end else begin
						bnd_vld  = 1'b1;
						bnd.nb   = 3'd1;
						bnd.code = pcc_pkg::CODE_ENC;
						bnd.ch   = ch_in;
						wr_n     = wr_q + CW'(1);
					end
				end
			end else if (!mkr_q) begin
				if (ch_in == pcc_pkg::eom_at(fill_q)) begin
					if (fill_q == 3'(pcc_pkg::EOM_LEN - 1)) begin
						mkr_n  = 1'b1;
						fill_n = '0;
					end else begin
						fill_n = fill_q + 3'd1;
					end
				end else begin
					fill_n   = fill_q + 3'd1 - rel;
					bnd_vld  = (sent != 3'd0);
					bnd.nb   = sent;
					bnd.pre  = (rel > fill_q) ? fill_q : rel;
					bnd.code = pcc_pkg::CODE_DEC;
					bnd.ch   = ch_in;
					wr_n     = wr_q + CW'(sent);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			ovf_q  <= 1'b0;
			mkr_q  <= 1'b0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_n;
			ovf_q  <= ovf_n;
			mkr_q  <= mkr_n;
			fill_q <= fill_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 3'd7)
		else $error("lookahead fill out of range");
	a_mkr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mkr_q |-> fill_q == 3'd0)
		else $error("window not empty after marker");
`endif

endmodule

// ===== rtl/pcc_coder.sv =====
// pcc_coder: shifts one letter or digit by the key and position residues, either direction
// depends on nothing; used by pcc_drain
module pcc_coder (
	input  logic [7:0] ch_in,
	input  logic       dec,
	input  logic [4:0] s26,
	input  logic [3:0] s10,
	input  logic [4:0] pos26,
	input  logic [2:0] pos5,
	output logic [7:0] ch_out,
	output logic       alnum
);

	logic [5:0] a26w;
	logic [4:0] a10w;
	logic [4:0] a26;
	logic [3:0] a10;
	logic       is_up, is_lo, is_dig;
	logic [7:0] base;
	logic [4:0] off26;
	logic [3:0] off10;
	logic [5:0] t26;
	logic [4:0] t10;
	logic [4:0] r26;
	logic [3:0] r10;

	assign a26w = {1'b0, s26} + {1'b0, pos26};
	assign a10w = {1'b0, s10} + {1'b0, pos5, 1'b0};
	assign a26  = (a26w >= 6'd26) ? 5'(a26w - 6'd26) : a26w[4:0];
	assign a10  = (a10w >= 5'd10) ? 4'(a10w - 5'd10) : a10w[3:0];

	assign is_up  = (ch_in >= 8'd65) && (ch_in <= 8'd90);
	assign is_lo  = (ch_in >= 8'd97) && (ch_in <= 8'd122);
	assign is_dig = (ch_in >= 8'd48) && (ch_in <= 8'd57);
	assign base   = is_lo ? 8'd97 : 8'd65;
	assign off26  = 5'(ch_in - base);
	assign off10  = 4'(ch_in - 8'd48);

	assign t26 = dec ? ({1'b0, off26} + 6'd26 - {1'b0, a26}) : ({1'b0, off26} + {1'b0, a26});
	assign t10 = dec ? ({1'b0, off10} + 5'd10 - {1'b0, a10}) : ({1'b0, off10} + {1'b0, a10});
	assign r26 = (t26 >= 6'd26) ? 5'(t26 - 6'd26) : t26[4:0];
	assign r10 = (t10 >= 5'd10) ? 4'(t10 - 5'd10) : t10[3:0];

	always_comb begin
		if (is_up || is_lo)
			ch_out = base + {3'd0, r26};
		else if (is_dig)
			ch_out = 8'd48 + {4'd0, r10};
		else
			ch_out = ch_in;
	end

	assign alnum = is_up | is_lo | is_dig;

endmodule

// ===== rtl/pcc_drain.sv =====
// pcc_drain: result register holding one bundle, sent out one beat at a time
// depends on pcc_pkg and pcc_coder; owns the position residues and the alphanumeric coded-byte count
module pcc_drain #(
	parameter int CW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pcc_pkg::cfg_t      cfg,
	input  logic               bnd_vld,
	input  pcc_pkg::bundle_t   bnd,
	output logic               load,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,
	output logic               m_tlast,
	output logic [0:0]         m_tuser
);

	logic             busy_q;
	logic [2:0]       idx_q;
	pcc_pkg::bundle_t desc_q;
	logic [4:0]       pos26_q;
	logic [2:0]       pos5_q;
	logic [CW-1:0]    alnum_q;

	logic [3:0] tot;
	logic       is_byte;
	logic       last_beat;
	logic       fire;
	logic       last_fire;
	logic       coded;
	logic [7:0] raw;
	logic [7:0] cod;
	logic       cod_alnum;
	logic [7:0] ch_o;
	logic [1:0] st_o;
	logic [15:0] cnt_o;

	assign tot       = {1'b0, desc_q.nb} + {3'd0, desc_q.fin};
	assign is_byte   = idx_q < desc_q.nb;
	assign last_beat = ({1'b0, idx_q} + 4'd1) == tot;
	assign fire      = busy_q & m_tready;
	assign last_fire = fire & last_beat;
	assign load      = !busy_q | last_fire;
	assign coded     = desc_q.code != pcc_pkg::CODE_RAW;
	assign raw       = (idx_q < desc_q.pre) ? pcc_pkg::eom_at(idx_q) : desc_q.ch;

	pcc_coder u_coder (
		.ch_in  (raw),
		.dec    (desc_q.code == pcc_pkg::CODE_DEC),
		.s26    (cfg.s26),
		.s10    (cfg.s10),
		.pos26  (pos26_q),
		.pos5   (pos5_q),
		.ch_out (cod),
		.alnum  (cod_alnum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= bnd_vld;
			idx_q  <= '0;
		end else if (fire) begin
			idx_q  <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			desc_q <= bnd;
	end

	// final beat closes the string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos26_q <= '0;
			pos5_q  <= '0;
			alnum_q <= '0;
		end else if (fire && !is_byte) begin
			pos26_q <= '0;
			pos5_q  <= '0;
			alnum_q <= '0;
		end else if (fire && coded) begin
			pos26_q <= (pos26_q == 5'd25) ? 5'd0 : pos26_q + 5'd1;
			pos5_q  <= (pos5_q == 3'd4) ? 3'd0 : pos5_q + 3'd1;
			alnum_q <= alnum_q + CW'(cod_alnum);
		end
	end

	assign ch_o  = !is_byte ? 8'd0 : (coded ? cod : raw);
	assign st_o  = is_byte ? pcc_pkg::ST_OK : desc_q.status;
	assign cnt_o = (!is_byte && desc_q.use_cnt) ? 16'(alnum_q) : 16'd0;

	assign m_tvalid = busy_q;
	assign m_tdata  = {6'd0, cnt_o, st_o, ch_o};
	assign m_tlast  = !is_byte;
	assign m_tuser  = is_byte;

`ifndef NO_ASSERTIONS
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> tot != 4'd0)
		else $error("empty bundle loaded");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> {1'b0, idx_q} < tot)
		else $error("beat index past bundle");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !m_tready |=> busy_q && $stable(idx_q))
		else $error("beat advanced while stalled");
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_byte |=> pos26_q == 5'd0 && pos5_q == 3'd0 && alnum_q == '0)
		else $error("string state kept after final beat");
`endif

endmodule

// ===== rtl/progressive_caesar_codec.sv =====
// progressive_caesar_codec: top level of the byte-serial progressive caesar codec
// depends on pcc_pkg, pcc_cfg, pcc_front, pcc_drain (and pcc_coder below it)
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   tdata char_in, tlast end_mark
//  m_*       out  m_tvalid / m_tready   tdata char_out status count, tuser has_char, tlast last
//  cfg_*     in   cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// each accepted beat is decided combinationally and lands in a result register; its output
// beats (none, one, or up to eight) leave one per cycle from it while m_tready is high
// a new input beat is taken in the cycle the last pending output beat leaves, so plain
// bytes stream one per cycle unless stalled; s_tready stays low until an item's last beat goes
// reset clears all string state and sets key 0, mode encrypt, capacity at its maximum
// a stall on m_tready holds the current output beat and, on its last beat, the input side
module progressive_caesar_codec #(
	parameter int MAX_CAPACITY = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] char_out, [9:8] status, [25:10] count
	output logic        m_tlast,
	output logic [0:0]  m_tuser,   // [0] has_char
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(MAX_CAPACITY + 1);

	pcc_pkg::cfg_t    cfg;
	logic [CW-1:0]    cap;
	logic             bnd_vld;
	pcc_pkg::bundle_t bnd;
	logic             load;

	pcc_cfg #(
		.MAX_CAPACITY (MAX_CAPACITY),
		.CW           (CW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.cap       (cap)
	);

	pcc_front #(
		.CW (CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (s_tvalid & s_tready),
		.ch_in    (s_tdata),
		.end_mark (s_tlast),
		.cfg      (cfg),
		.cap      (cap),
		.bnd_vld  (bnd_vld),
		.bnd      (bnd)
	);

	pcc_drain #(
		.CW (CW)
	) u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.bnd_vld  (bnd_vld),
		.bnd      (bnd),
		.load     (load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	assign s_tready = load;

endmodule
